FILE: hw/rtl/pfc_pkg.sv
package pfc_pkg;
    localparam int DATA_W = 32;
    localparam int BTN_W = 20;
    localparam int SEG_W = 7;
    localparam int DISPLAY_DIGITS = 8;
    localparam int NUM_POS = 8;

    localparam logic [1:0] OPN_NONE = 2'd0;
    localparam logic [1:0] OPN_ADD = 2'd1;
    localparam logic [1:0] OPN_SUB = 2'd2;
    localparam logic [1:0] OPN_MUL = 2'd3;

    // serial unit operations
    localparam logic [2:0] ALU_ADD = 3'd0;
    localparam logic [2:0] ALU_SUB = 3'd1;
    localparam logic [2:0] ALU_MUL = 3'd2;
    localparam logic [2:0] ALU_DIV = 3'd3;

    localparam logic [SEG_W-1:0] MINUS_CODE = 7'h40;

    typedef logic [SEG_W-1:0] t_seg;

    function automatic t_seg digit_font(input logic [3:0] d);
        t_seg s;
        case (d)
            4'd0: s = 7'h3F;
            4'd1: s = 7'h06;
            4'd2: s = 7'h5B;
            4'd3: s = 7'h4F;
            4'd4: s = 7'h66;
            4'd5: s = 7'h6D;
            4'd6: s = 7'h7D;
            4'd7: s = 7'h07;
            4'd8: s = 7'h7F;
            4'd9: s = 7'h6F;
            default: s = 7'h00;
        endcase
        return s;
    endfunction
endpackage

FILE: hw/rtl/pfc_alu.sv
// Bit-serial 32-bit unit: add/sub in one pass per bit, multiply by
// shift-and-add (one multiplier bit per cycle), divide by ten by
// restoring division (one quotient bit per cycle).
module pfc_alu (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [2:0]           i_op,      // 0 add 1 sub 2 mul 3 div10
    input  logic [pfc_pkg::DATA_W-1:0] i_a,
    input  logic [pfc_pkg::DATA_W-1:0] i_b,
    output logic                 o_done,
    output logic [pfc_pkg::DATA_W-1:0] o_res,
    output logic [3:0]           o_rem
);
    import pfc_pkg::*;

    logic              r_busy, n_busy;
    logic [2:0]        r_op, n_op;
    logic [5:0]        r_cnt, n_cnt;
    logic [DATA_W-1:0] r_a, n_a;
    logic [DATA_W-1:0] r_b, n_b;
    logic [DATA_W-1:0] r_acc, n_acc;
    logic              r_c, n_c;
    logic [4:0]        r_rm, n_rm;
    logic              r_done, n_done;
    logic              bb, sbit;
    logic [4:0]        trial;

    always_comb begin
        n_busy = r_busy;
        n_op = r_op;
        n_cnt = r_cnt;
        n_a = r_a;
        n_b = r_b;
        n_acc = r_acc;
        n_c = r_c;
        n_rm = r_rm;
        n_done = 1'b0;
        bb = 1'b0;
        sbit = 1'b0;
        trial = 5'd0;
        if (i_start) begin
            n_busy = 1'b1;
            n_op = i_op;
            n_cnt = 6'd0;
            n_a = i_a;
            n_b = i_b;
            n_acc = '0;
            n_c = (i_op == ALU_SUB);
            n_rm = 5'd0;
        end else if (r_busy) begin
            case (r_op)
                ALU_ADD, ALU_SUB: begin
                    bb = (r_op == ALU_SUB) ? ~r_b[0] : r_b[0];
                    sbit = r_a[0] ^ bb ^ r_c;
                    n_c = (r_a[0] & bb) | (r_a[0] & r_c) | (bb & r_c);
                    n_a = r_a >> 1;
                    n_b = r_b >> 1;
                    n_acc = {sbit, r_acc[DATA_W-1:1]};
                end
                ALU_MUL: begin
                    // a holds shifted multiplicand, b the remaining multiplier
                    if (r_b[0]) n_acc = r_acc + r_a;
                    n_a = r_a << 1;
                    n_b = r_b >> 1;
                end
                default: begin
                    trial = {r_rm[3:0], r_a[DATA_W-1]};
                    n_a = r_a << 1;
                    if (trial >= 5'd10) begin
                        n_rm = trial - 5'd10;
                        n_acc = {r_acc[DATA_W-2:0], 1'b1};
                    end else begin
                        n_rm = trial;
                        n_acc = {r_acc[DATA_W-2:0], 1'b0};
                    end
                end
            endcase
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'(DATA_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_op <= n_op;
        r_cnt <= n_cnt;
        r_a <= n_a;
        r_b <= n_b;
        r_acc <= n_acc;
        r_c <= n_c;
        r_rm <= n_rm;
    end

    assign o_done = r_done;
    assign o_res = r_acc;
    assign o_rem = r_rm[3:0];

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("done without busy");
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && r_op == ALU_DIV |-> r_rm < 5'd10) else $error("remainder out of range");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt < 6'(DATA_W)) else $error("count overrun");
endmodule

FILE: hw/rtl/pushbutton_four_function_calculator.sv
// Steps: the first digit of an entry is loaded directly; each later digit runs
// a serial multiply by ten, then a serial add of the digit. An operator or
// equals that applies an operation runs one serial pass, a negative value is
// negated through the serial unit, and each shown decimal digit takes one pass.
// One poll is handled at a time; the next is taken once the sequencer is idle,
// while a finished result waits in the output registers. Reset (synchronous,
// active low) clears the working values and output valid, not the segments.
module pushbutton_four_function_calculator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [pfc_pkg::BTN_W-1:0]     i_buttons,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [pfc_pkg::SEG_W-1:0]     o_segments_0,
    output logic [pfc_pkg::SEG_W-1:0]     o_segments_1,
    output logic [pfc_pkg::SEG_W-1:0]     o_segments_2,
    output logic [pfc_pkg::SEG_W-1:0]     o_segments_3,
    output logic [pfc_pkg::SEG_W-1:0]     o_segments_4,
    output logic [pfc_pkg::SEG_W-1:0]     o_segments_5,
    output logic [pfc_pkg::SEG_W-1:0]     o_segments_6,
    output logic [pfc_pkg::SEG_W-1:0]     o_segments_7,
    output logic                          o_display_changed
);
    import pfc_pkg::*;

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DIGIT  = 4'd1;  // scan next pressed digit
    localparam logic [3:0] S_DMUL   = 4'd2;  // wait entry*10
    localparam logic [3:0] S_DADD   = 4'd3;  // wait +digit
    localparam logic [3:0] S_OPER   = 4'd4;
    localparam logic [3:0] S_OWAIT  = 4'd5;
    localparam logic [3:0] S_RSTART = 4'd6;
    localparam logic [3:0] S_NEG    = 4'd7;
    localparam logic [3:0] S_RDIV   = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    logic [3:0]        r_state, n_state;
    logic [BTN_W-1:0]  r_prev, n_prev;
    logic [BTN_W-1:0]  r_press, n_press;
    logic [DATA_W-1:0] r_accv, n_accv;
    logic [DATA_W-1:0] r_entry, n_entry;
    logic              r_started, n_started;
    logic [1:0]        r_pend, n_pend;
    logic [1:0]        r_rop, n_rop;
    logic [DATA_W-1:0] r_ropnd, n_ropnd;
    logic [DATA_W-1:0] r_shown, n_shown;
    logic [3:0]        r_dig, n_dig;
    logic              r_changed, n_changed;
    logic              r_negf, n_negf;
    logic [3:0]        r_cnt, n_cnt;       // digits rendered
    t_seg              r_seg [NUM_POS], n_seg [NUM_POS];
    // result held for the receiver, apart from the working display
    t_seg              r_oseg [NUM_POS], n_oseg [NUM_POS];
    logic              r_ochanged, n_ochanged;
    logic              r_ovalid, n_ovalid;

    logic              alu_start, alu_done;
    logic [2:0]        alu_op;
    logic [DATA_W-1:0] alu_a, alu_b, alu_res;
    logic [3:0]        alu_rem;
    logic [1:0]        chosen;
    logic [3:0]        lowest;
    logic              any_dig;

    pfc_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (alu_start),
        .i_op    (alu_op),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_done  (alu_done),
        .o_res   (alu_res),
        .o_rem   (alu_rem)
    );

    function automatic logic [2:0] to_alu(input logic [1:0] op);
        logic [2:0] r;
        case (op)
            OPN_ADD: r = ALU_ADD;
            OPN_SUB: r = ALU_SUB;
            default: r = ALU_MUL;
        endcase
        return r;
    endfunction

    // take a new poll whenever the sequencer is idle
    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        // lowest pressed digit key
        any_dig = |r_press[9:0];
        lowest = 4'd0;
        for (int k = 9; k >= 0; k--) begin
            if (r_press[k]) lowest = 4'(k);
        end
    end

    always_comb begin
        n_state = r_state;
        n_prev = r_prev;
        n_press = r_press;
        n_accv = r_accv;
        n_entry = r_entry;
        n_started = r_started;
        n_pend = r_pend;
        n_rop = r_rop;
        n_ropnd = r_ropnd;
        n_shown = r_shown;
        n_dig = r_dig;
        n_changed = r_changed;
        n_negf = r_negf;
        n_cnt = r_cnt;
        n_seg = r_seg;
        n_oseg = r_oseg;
        n_ochanged = r_ochanged;
        n_ovalid = r_ovalid;
        alu_start = 1'b0;
        alu_op = ALU_ADD;
        alu_a = r_entry;
        alu_b = r_entry;
        chosen = OPN_NONE;

        if (r_ovalid && i_ready) n_ovalid = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    // edge detect against the previous poll
                    n_press = i_buttons & ~r_prev;
                    n_prev = i_buttons;
                    n_changed = 1'b0;
                    n_state = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (any_dig) begin
                    n_press[{1'b0, lowest}] = 1'b0;
                    n_dig = lowest;
                    n_changed = 1'b1;
                    if (r_started) begin
                        alu_start = 1'b1;
                        alu_op = ALU_MUL;
                        alu_a = r_entry;
                        alu_b = DATA_W'(10);
                        n_state = S_DMUL;
                    end else begin
                        n_entry = DATA_W'(lowest);
                        n_started = 1'b1;
                        n_shown = DATA_W'(lowest);
                    end
                end else begin
                    n_state = S_OPER;
                end
            end
            S_DMUL: begin
                if (alu_done) begin
                    alu_start = 1'b1;
                    alu_op = ALU_ADD;
                    alu_a = alu_res;
                    alu_b = DATA_W'(r_dig);
                    n_state = S_DADD;
                end
            end
            S_DADD: begin
                if (alu_done) begin
                    n_entry = alu_res;
                    n_shown = alu_res;
                    n_state = S_DIGIT;
                end
            end
            S_OPER: begin
                if (r_press[19]) chosen = OPN_ADD;
                if (r_press[18]) chosen = OPN_SUB;
                if (r_press[17]) chosen = OPN_MUL;
                if (r_press[19] || r_press[18] || r_press[17] || r_press[16]) begin
                    n_changed = 1'b1;
                    n_pend = r_press[16] ? OPN_NONE : chosen;
                    n_started = 1'b0;
                    n_state = S_RSTART;
                    if (r_pend != OPN_NONE) begin
                        if (r_started) begin
                            alu_start = 1'b1;
                            alu_op = to_alu(r_pend);
                            alu_a = r_accv;
                            alu_b = r_entry;
                            n_rop = r_pend;
                            n_ropnd = r_entry;
                            n_state = S_OWAIT;
                        end else begin
                            n_shown = r_accv;
                        end
                    end else if (r_started) begin
                        n_accv = r_entry;
                        n_shown = r_entry;
                    end else if (r_press[16] && r_rop != OPN_NONE) begin
                        alu_start = 1'b1;
                        alu_op = to_alu(r_rop);
                        alu_a = r_accv;
                        alu_b = r_ropnd;
                        n_state = S_OWAIT;
                    end else begin
                        n_shown = r_accv;
                    end
                end else begin
                    n_state = S_RSTART;
                end
            end
            S_OWAIT: begin
                if (alu_done) begin
                    n_accv = alu_res;
                    n_shown = alu_res;
                    n_state = S_RSTART;
                end
            end
            S_RSTART: begin
                // if negative, take the magnitude: negate through the serial unit
                n_negf = r_shown[DATA_W-1];
                n_cnt = 4'd0;
                for (int p = 0; p < NUM_POS; p++) n_seg[p] = '0;
                if (r_shown[DATA_W-1]) begin
                    alu_start = 1'b1;
                    alu_op = ALU_SUB;
                    alu_a = '0;
                    alu_b = r_shown;
                    n_state = S_NEG;
                end else if (r_shown == '0) begin
                    n_seg[0] = digit_font(4'd0);
                    n_cnt = 4'd1;
                    n_state = S_OUT;
                end else begin
                    alu_start = 1'b1;
                    alu_op = ALU_DIV;
                    alu_a = r_shown;
                    n_state = S_RDIV;
                end
            end
            S_NEG: begin
                if (alu_done) begin
                    alu_start = 1'b1;
                    alu_op = ALU_DIV;
                    alu_a = alu_res;
                    n_state = S_RDIV;
                end
            end
            S_RDIV: begin
                // one decimal digit per division pass
                if (alu_done) begin
                    n_seg[r_cnt[2:0]] = digit_font(alu_rem);
                    n_cnt = r_cnt + 4'd1;
                    if (alu_res != '0 && r_cnt + 4'd1 < 4'(DISPLAY_DIGITS)) begin
                        alu_start = 1'b1;
                        alu_op = ALU_DIV;
                        alu_a = alu_res;
                        n_state = S_RDIV;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (r_negf && r_cnt < 4'(DISPLAY_DIGITS)) n_seg[r_cnt[2:0]] = MINUS_CODE;
                // hold here until the output registers are free
                if (!r_ovalid || i_ready) begin
                    n_oseg = n_seg;
                    n_ochanged = r_changed;
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_prev <= '0;
            r_accv <= '0;
            r_entry <= '0;
            r_started <= 1'b0;
            r_pend <= OPN_NONE;
            r_rop <= OPN_NONE;
            r_ropnd <= '0;
            r_shown <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_prev <= n_prev;
            r_accv <= n_accv;
            r_entry <= n_entry;
            r_started <= n_started;
            r_pend <= n_pend;
            r_rop <= n_rop;
            r_ropnd <= n_ropnd;
            r_shown <= n_shown;
            r_ovalid <= n_ovalid;
        end
        r_press <= n_press;
        r_dig <= n_dig;
        r_changed <= n_changed;
        r_negf <= n_negf;
        r_cnt <= n_cnt;
        r_seg <= n_seg;
        r_oseg <= n_oseg;
        r_ochanged <= n_ochanged;
    end

    assign o_valid = r_ovalid;
    assign o_segments_0 = r_oseg[0];
    assign o_segments_1 = r_oseg[1];
    assign o_segments_2 = r_oseg[2];
    assign o_segments_3 = r_oseg[3];
    assign o_segments_4 = r_oseg[4];
    assign o_segments_5 = r_oseg[5];
    assign o_segments_6 = r_oseg[6];
    assign o_segments_7 = r_oseg[7];
    assign o_display_changed = r_ochanged;

    a_out_from_render: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == S_OUT) else $error("result not from render");
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !i_ready |=> r_ovalid && $stable(o_segments_0)
            && $stable(o_display_changed)) else $error("result changed while waiting");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_pos0_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> r_oseg[0] != '0) else $error("position 0 unlit");
endmodule
